// File: rtl/assert_macros.svh
// Assertion shorthands shared by the row table RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/lrt_pkg.sv
// Shared widths, command and error codes, and control structs for the row table.
// No dependencies; imported by every module of the block.
package lrt_pkg;

  localparam int MAX_ROWS_DEF = 1024;
  localparam int CNT_W        = 17;   // compare width, holds any row count up to 65536
  localparam int ROW_W        = 10;
  localparam int RC_W         = 11;
  localparam int FUNC_W       = 2;
  localparam int ERR_W        = 2;
  localparam int CFG_IDX_W    = 1;

  localparam logic [FUNC_W-1:0] FUNC_UP      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DOWN    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESTORE = 2'd3;

  localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY_UNDO = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SOLE_ROW   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 1'd1;

  localparam logic [RC_W-1:0]  ROW_COUNT_RST = 11'd1024;
  localparam logic [ROW_W-1:0] START_ROW_RST = 10'd0;

  // Write strobes toward the link and mark memories.
  typedef struct packed {
    logic prev_we;
    logic next_we;
    logic mark_we;
    logic mark_val;
  } link_wr_t;

  // Undo stack commands.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } undo_ctl_t;

endpackage

// File: rtl/lrt_link_mem.sv
// Link memories (prev and next, with a none flag on top) and the removed-mark memory.
// Depends on lrt_pkg for link_wr_t.
module lrt_link_mem
  import lrt_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int LW = RW + 1
) (
  input  logic          clk,
  input  logic [RW-1:0] rd_addr,
  output logic [LW-1:0] prev_q,
  output logic [LW-1:0] next_q,
  input  logic [RW-1:0] mark_rd_addr,
  output logic          mark_q,
  input  link_wr_t      wr,
  input  logic [RW-1:0] prev_wa,
  input  logic [LW-1:0] prev_wd,
  input  logic [RW-1:0] next_wa,
  input  logic [LW-1:0] next_wd,
  input  logic [RW-1:0] mark_wa
);

  logic [LW-1:0] prev_mem [MAX_ROWS];
  logic [LW-1:0] next_mem [MAX_ROWS];
  logic          mark_mem [MAX_ROWS];

  always_ff @(posedge clk) begin
    if (wr.prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.mark_we) begin
      mark_mem[mark_wa] <= wr.mark_val;
    end
    mark_q <= mark_mem[mark_rd_addr];
  end

endmodule

// File: rtl/lrt_undo.sv
// Undo stack of deleted rows: a memory and its depth pointer.
// Depends on lrt_pkg for undo_ctl_t.
module lrt_undo
  import lrt_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int DW = $clog2(MAX_ROWS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  undo_ctl_t     ctl,
  input  logic [RW-1:0] push_row,
  output logic [DW-1:0] depth,
  output logic [RW-1:0] top_q
);

  logic [RW-1:0] stack_mem [MAX_ROWS];
  logic [DW-1:0] depth_r, depth_nxt;
  logic [RW-1:0] rd_idx;
  logic          push_ok;

  assign push_ok = ctl.push && (depth_r < DW'(MAX_ROWS));
  assign rd_idx  = RW'(depth_r - DW'(1));
  assign depth   = depth_r;

  always_comb begin
    depth_nxt = depth_r;
    if (ctl.clear) begin
      depth_nxt = '0;
    end else if (push_ok) begin
      depth_nxt = depth_r + DW'(1);
    end else if (ctl.pop && (depth_r != '0)) begin
      depth_nxt = depth_r - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // pop reads the entry below the current depth; data is ready next cycle
  always_ff @(posedge clk) begin
    if (push_ok) begin
      stack_mem[depth_r[RW-1:0]] <= push_row;
    end
    if (ctl.pop) begin
      top_q <= stack_mem[rd_idx];
    end
  end

endmodule

// File: rtl/lrt_ctrl.sv
// Sequencer for the row table: clearing sweep, move walker, delete and restore.
// Depends on lrt_pkg and assert_macros.svh; drives lrt_link_mem and lrt_undo.
`include "assert_macros.svh"

module lrt_ctrl
  import lrt_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int LW = RW + 1,
  localparam int NW = $clog2(MAX_ROWS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic [NW-1:0]     rows_used,
  input  logic [RW-1:0]     cursor_init,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ROW_W-1:0]  in_distance,
  input  logic [ROW_W-1:0]  in_probe_row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic              out_probe_removed,
  output logic [ERR_W-1:0]  out_error_code,
  output logic [RW-1:0]     rd_addr,
  input  logic [LW-1:0]     prev_q,
  input  logic [LW-1:0]     next_q,
  output logic [RW-1:0]     mark_rd_addr,
  input  logic              mark_q,
  output link_wr_t          lwr,
  output logic [RW-1:0]     prev_wa,
  output logic [LW-1:0]     prev_wd,
  output logic [RW-1:0]     next_wa,
  output logic [LW-1:0]     next_wd,
  output logic [RW-1:0]     mark_wa,
  output undo_ctl_t         uctl,
  output logic [RW-1:0]     push_row,
  input  logic [NW-1:0]     undo_depth,
  input  logic [RW-1:0]     undo_q
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_DEL   = 3'd3;
  localparam logic [2:0] S_RST1  = 3'd4;
  localparam logic [2:0] S_RST2  = 3'd5;
  localparam logic [2:0] S_PROBE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [LW-1:0] LINK_NONE = {1'b1, {RW{1'b0}}};

  logic [2:0]        state_r, state_nxt;
  logic [RW-1:0]     sweep_r, sweep_nxt;
  logic [RW-1:0]     cursor_r, cursor_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [ROW_W-1:0]  dist_r, dist_nxt;
  logic [ROW_W-1:0]  probe_r, probe_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]  out_cursor_r, out_cursor_nxt;
  logic              out_removed_r, out_removed_nxt;
  logic [ERR_W-1:0]  out_err_r, out_err_nxt;

  logic              in_acc;
  logic              p_none, n_none;
  logic [LW-1:0]     hop_q;
  logic              hop_done;
  logic              probe_ok;
  logic [CNT_W-1:0]  sweep_plus;

  assign in_stall          = (state_r != S_IDLE);
  assign in_acc            = in_valid && (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_cursor_row    = out_cursor_r;
  assign out_probe_removed = out_removed_r;
  assign out_error_code    = out_err_r;

  assign p_none       = prev_q[LW-1];
  assign n_none       = next_q[LW-1];
  assign mark_rd_addr = RW'(probe_r);
  assign probe_ok     = CNT_W'(probe_r) < CNT_W'(rows_used);
  assign sweep_plus   = CNT_W'(sweep_r) + CNT_W'(1);

  // walker: one link hop and one count step per cycle
  assign hop_q    = (func_r == FUNC_UP) ? prev_q : next_q;
  assign hop_done = (dist_r == '0) || hop_q[LW-1];

  always_comb begin
    state_nxt       = state_r;
    sweep_nxt       = sweep_r;
    cursor_nxt      = cursor_r;
    row_nxt         = row_r;
    func_nxt        = func_r;
    dist_nxt        = dist_r;
    probe_nxt       = probe_r;
    err_nxt         = err_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_cursor_nxt  = out_cursor_r;
    out_removed_nxt = out_removed_r;
    out_err_nxt     = out_err_r;
    rd_addr         = cursor_r;
    lwr             = '0;
    prev_wa         = sweep_r;
    prev_wd         = LINK_NONE;
    next_wa         = sweep_r;
    next_wd         = LINK_NONE;
    mark_wa         = sweep_r;
    uctl            = '0;
    push_row        = cursor_r;

    case (state_r)
      S_INIT: begin
        // rebuild the chain one row per cycle
        uctl.clear   = 1'b1;
        cursor_nxt   = cursor_init;
        lwr.prev_we  = 1'b1;
        lwr.next_we  = 1'b1;
        lwr.mark_we  = 1'b1;
        lwr.mark_val = 1'b0;
        prev_wd      = (sweep_r == '0) ? LINK_NONE : {1'b0, sweep_r - RW'(1)};
        next_wd      = (sweep_plus >= CNT_W'(rows_used)) ? LINK_NONE
                                                         : {1'b0, sweep_r + RW'(1)};
        if (sweep_r == RW'(MAX_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + RW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          func_nxt  = in_func;
          dist_nxt  = in_distance;
          probe_nxt = in_probe_row;
          err_nxt   = ERR_OK;
          case (in_func)
            FUNC_UP, FUNC_DOWN: begin
              state_nxt = S_MOVE;
            end
            FUNC_DEL: begin
              state_nxt = S_DEL;
            end
            default: begin
              if (undo_depth == '0) begin
                err_nxt   = ERR_EMPTY_UNDO;
                state_nxt = S_PROBE;
              end else begin
                uctl.pop  = 1'b1;
                state_nxt = S_RST1;
              end
            end
          endcase
        end
      end
      S_MOVE: begin
        if (hop_done) begin
          state_nxt = S_PROBE;
        end else begin
          cursor_nxt = hop_q[RW-1:0];
          dist_nxt   = dist_r - ROW_W'(1);
          rd_addr    = hop_q[RW-1:0];
        end
      end
      S_DEL: begin
        if (p_none && n_none) begin
          err_nxt = ERR_SOLE_ROW;
        end else begin
          uctl.push    = 1'b1;
          lwr.mark_we  = 1'b1;
          lwr.mark_val = 1'b1;
          mark_wa      = cursor_r;
          lwr.next_we  = !p_none;
          next_wa      = prev_q[RW-1:0];
          next_wd      = next_q;
          lwr.prev_we  = !n_none;
          prev_wa      = next_q[RW-1:0];
          prev_wd      = prev_q;
          cursor_nxt   = n_none ? prev_q[RW-1:0] : next_q[RW-1:0];
        end
        state_nxt = S_PROBE;
      end
      S_RST1: begin
        rd_addr   = undo_q;
        row_nxt   = undo_q;
        state_nxt = S_RST2;
      end
      S_RST2: begin
        // links of a restored row still name its old neighbors
        lwr.mark_we  = 1'b1;
        lwr.mark_val = 1'b0;
        mark_wa      = row_r;
        lwr.next_we  = !p_none;
        next_wa      = prev_q[RW-1:0];
        next_wd      = {1'b0, row_r};
        lwr.prev_we  = !n_none;
        prev_wa      = next_q[RW-1:0];
        prev_wd      = {1'b0, row_r};
        state_nxt    = S_PROBE;
      end
      S_PROBE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_cursor_nxt  = ROW_W'(cursor_r);
          out_removed_nxt = probe_ok && mark_q;
          out_err_nxt     = err_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    if (restart) begin
      uctl.clear = 1'b1;
      state_nxt  = S_INIT;
      sweep_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cursor_r      <= cursor_nxt;
    row_r         <= row_nxt;
    func_r        <= func_nxt;
    dist_r        <= dist_nxt;
    probe_r       <= probe_nxt;
    err_r         <= err_nxt;
    out_cursor_r  <= out_cursor_nxt;
    out_removed_r <= out_removed_nxt;
    out_err_r     <= out_err_nxt;
  end

  `ASSERT_ALWAYS(a_depth_bound, CNT_W'(undo_depth) < CNT_W'(rows_used), "undo depth reached row count")
  `ASSERT_IMPL(a_cursor_range, state_r != S_INIT, CNT_W'(cursor_r) < CNT_W'(rows_used), "cursor outside table")
  `ASSERT_IMPL(a_out_load, $rose(out_valid_r), $past(state_r) == S_DONE, "result beat not from done state")
  `ASSERT_IMPL(a_move_quiet, state_r == S_MOVE, !lwr.mark_we && !uctl.push, "move modified table")

endmodule

// File: rtl/linked_row_table_with_undo.sv
// Linked row table with undo: rows 0..n-1, n being the row count clamped into
// 2..MAX_ROWS, form a doubly linked list in two link memories, with a cursor, a
// removed-mark memory and a LIFO undo stack. After reset and after every
// configuration write the block runs a clearing sweep over all MAX_ROWS rows (one
// row per cycle) and holds in_stall high meanwhile; config writes are still taken
// and restart the sweep. Items are handled one at a time by a sequencer around one
// link-walk unit. A delete passes through the delete, probe and done states; a
// restore through two restore states (skipped for an empty stack), then probe and
// done; a move through the move state, where the walker follows one link per cycle
// through the registered memory read port for each hop (at most distance), then probe and done.
// The done state loads the result register once any earlier beat has left it and
// returns to idle, where the next item is taken; so the next item may be accepted
// while the previous result beat waits on out_stall in the output register.
// Depends on lrt_pkg, lrt_link_mem, lrt_undo and lrt_ctrl.
module linked_row_table_with_undo
  import lrt_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [RC_W-1:0]      cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [ROW_W-1:0]     in_distance,
  input  logic [ROW_W-1:0]     in_probe_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ROW_W-1:0]     out_cursor_row,
  output logic                 out_probe_removed,
  output logic [ERR_W-1:0]     out_error_code
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int LW = RW + 1;
  localparam int NW = $clog2(MAX_ROWS + 1);

  // Configuration registers
  logic [RC_W-1:0]  row_count_r, row_count_nxt;
  logic [ROW_W-1:0] start_row_r, start_row_nxt;

  always_comb begin
    row_count_nxt = row_count_r;
    start_row_nxt = start_row_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_ROW_COUNT: row_count_nxt = cfg_wdata;
        REG_START_ROW: start_row_nxt = cfg_wdata[ROW_W-1:0];
        default: begin
          row_count_nxt = row_count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      start_row_r <= START_ROW_RST;
    end else begin
      row_count_r <= row_count_nxt;
      start_row_r <= start_row_nxt;
    end
  end

  // Clamp the row count into 2..MAX_ROWS and the start row to the last row
  logic [CNT_W-1:0] rc_ext, n_ext, sr_ext, cur_ext;
  logic [NW-1:0]    rows_used;
  logic [RW-1:0]    cursor_init;

  always_comb begin
    rc_ext = CNT_W'(row_count_r);
    if (rc_ext < CNT_W'(2)) begin
      n_ext = CNT_W'(2);
    end else if (rc_ext > CNT_W'(MAX_ROWS)) begin
      n_ext = CNT_W'(MAX_ROWS);
    end else begin
      n_ext = rc_ext;
    end
    sr_ext  = CNT_W'(start_row_r);
    cur_ext = (sr_ext >= n_ext) ? n_ext - CNT_W'(1) : sr_ext;
  end

  assign rows_used   = NW'(n_ext);
  assign cursor_init = RW'(cur_ext);

  // Memory and stack wiring
  logic [RW-1:0] rd_addr, mark_rd_addr, prev_wa, next_wa, mark_wa;
  logic [LW-1:0] prev_q, next_q, prev_wd, next_wd;
  logic          mark_q;
  link_wr_t      lwr;
  undo_ctl_t     uctl;
  logic [RW-1:0] push_row, undo_q;
  logic [NW-1:0] undo_depth;

  lrt_ctrl #(
    .MAX_ROWS(MAX_ROWS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .restart          (cfg_we),
    .rows_used        (rows_used),
    .cursor_init      (cursor_init),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_distance      (in_distance),
    .in_probe_row     (in_probe_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cursor_row   (out_cursor_row),
    .out_probe_removed(out_probe_removed),
    .out_error_code   (out_error_code),
    .rd_addr          (rd_addr),
    .prev_q           (prev_q),
    .next_q           (next_q),
    .mark_rd_addr     (mark_rd_addr),
    .mark_q           (mark_q),
    .lwr              (lwr),
    .prev_wa          (prev_wa),
    .prev_wd          (prev_wd),
    .next_wa          (next_wa),
    .next_wd          (next_wd),
    .mark_wa          (mark_wa),
    .uctl             (uctl),
    .push_row         (push_row),
    .undo_depth       (undo_depth),
    .undo_q           (undo_q)
  );

  lrt_link_mem #(
    .MAX_ROWS(MAX_ROWS)
  ) u_link_mem (
    .clk         (clk),
    .rd_addr     (rd_addr),
    .prev_q      (prev_q),
    .next_q      (next_q),
    .mark_rd_addr(mark_rd_addr),
    .mark_q      (mark_q),
    .wr          (lwr),
    .prev_wa     (prev_wa),
    .prev_wd     (prev_wd),
    .next_wa     (next_wa),
    .next_wd     (next_wd),
    .mark_wa     (mark_wa)
  );

  lrt_undo #(
    .MAX_ROWS(MAX_ROWS)
  ) u_undo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (uctl),
    .push_row(push_row),
    .depth   (undo_depth),
    .top_q   (undo_q)
  );

endmodule
